>>> hdl/pbnc_pkg.sv
// Shared types, constants and the alpha weight table for the palette blend unit.
package pbnc_pkg;

  localparam int PALETTE_ENTRIES_DEF = 256;
  localparam int FRAC_BITS           = 12;
  localparam int PERCENT_SCALE       = 100;
  localparam int ALPHA_MAX           = 99;
  localparam int ALPHA_W             = 7;
  localparam int ALPHA_RESET         = 66;
  localparam int COMP_W              = 8;
  localparam int RGB_W               = 3 * COMP_W;
  localparam int W_W                 = 12;  // largest weight is 4055
  localparam int B_W                 = 20;  // blended component, at most 255 * 4096
  localparam int PROD_W              = COMP_W + B_W;
  localparam int PSUM_W              = PROD_W + 2;
  localparam int SQ_W                = 2 * COMP_W + 2;  // three squares reach 195075
  localparam int SQ_SHIFT            = FRAC_BITS - 1;
  localparam int ERR_W               = PSUM_W + 1;
  localparam int QDEPTH              = 2;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } op_t;

  typedef struct packed {
    op_t               op;
    logic              load_ok;
    logic [7:0]        entry_index;
    logic [RGB_W-1:0]  rgb;
    logic [7:0]        first_color;
    logic              first_ok;
    logic [7:0]        second_color;
    logic              second_ok;
  } item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD1,
    S_RD2,
    S_BLEND,
    S_SCAN,
    S_DRAIN,
    S_DONE
  } back_state_t;

  typedef logic [W_W-1:0] weight_t;
  typedef weight_t weight_table_t [2**ALPHA_W];

  // Weight of the second color for every register code; codes above the
  // top percentage saturate.
  function automatic weight_table_t build_w1_table();
    weight_table_t t;
    int a;
    for (int i = 0; i < 2**ALPHA_W; i++) begin
      a = (i > ALPHA_MAX) ? ALPHA_MAX : i;
      t[i] = W_W'((a << FRAC_BITS) / PERCENT_SCALE);
    end
    return t;
  endfunction

  localparam weight_table_t W1_TABLE = build_w1_table();

endpackage

>>> hdl/pbnc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pbnc_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> hdl/pbnc_front.sv
// Front end: classifies incoming beats and holds them in a short queue.
module pbnc_front #(
  parameter int PALETTE_ENTRIES = pbnc_pkg::PALETTE_ENTRIES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_cmd,
  input  logic [7:0]          in_entry_index,
  input  logic [7:0]          in_red,
  input  logic [7:0]          in_green,
  input  logic [7:0]          in_blue,
  input  logic [7:0]          in_first_color,
  input  logic [7:0]          in_second_color,
  output logic                q_valid,
  output pbnc_pkg::item_t     q_item,
  input  logic                q_pop
);

  localparam int PW = (pbnc_pkg::QDEPTH > 1) ? $clog2(pbnc_pkg::QDEPTH) : 1;
  localparam int CW = $clog2(pbnc_pkg::QDEPTH + 1);
  localparam logic [8:0] LIMIT = 9'(PALETTE_ENTRIES);

  pbnc_pkg::item_t qmem_r [pbnc_pkg::QDEPTH];
  pbnc_pkg::item_t item_in;
  logic [PW-1:0]   wptr_r, wptr_nxt, rptr_r, rptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic            push;

  // Decode the beat and check its indices against the palette size.
  always_comb begin
    item_in.op           = pbnc_pkg::op_t'(in_cmd);
    item_in.load_ok      = ({1'b0, in_entry_index} < LIMIT);
    item_in.entry_index  = in_entry_index;
    item_in.rgb          = {in_red, in_green, in_blue};
    item_in.first_color  = in_first_color;
    item_in.first_ok     = ({1'b0, in_first_color} < LIMIT);
    item_in.second_color = in_second_color;
    item_in.second_ok    = ({1'b0, in_second_color} < LIMIT);
  end

  assign in_stall = (count_r == CW'(pbnc_pkg::QDEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count_r != '0);
  assign q_item   = qmem_r[rptr_r];

  always_comb begin
    wptr_nxt  = wptr_r;
    rptr_nxt  = rptr_r;
    count_nxt = count_r;
    if (push) begin
      wptr_nxt = (wptr_r == PW'(pbnc_pkg::QDEPTH - 1)) ? '0 : wptr_r + 1'b1;
    end
    if (q_pop) begin
      rptr_nxt = (rptr_r == PW'(pbnc_pkg::QDEPTH - 1)) ? '0 : rptr_r + 1'b1;
    end
    if (push && !q_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push && q_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      qmem_r[wptr_r] <= item_in;
    end
  end

endmodule

>>> hdl/pbnc_back.sv
// Back end: palette writes, blend of the two query colors and the nearest-entry scan.
module pbnc_back #(
  parameter int PALETTE_ENTRIES = pbnc_pkg::PALETTE_ENTRIES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_valid,
  input  pbnc_pkg::item_t       q_item,
  output logic                  q_pop,
  input  pbnc_pkg::weight_t     w1,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [7:0]            out_nearest_index
);

  localparam int AW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
  localparam int CW = pbnc_pkg::COMP_W;
  localparam int BW = pbnc_pkg::B_W;

  pbnc_pkg::back_state_t state_r, state_nxt;

  logic                        ram_we;
  logic [AW-1:0]               ram_waddr, ram_raddr;
  logic [pbnc_pkg::RGB_W-1:0]  ram_rdata;

  // Query context.
  pbnc_pkg::item_t             qry_r, qry_nxt;
  logic [pbnc_pkg::RGB_W-1:0]  c1_r, c1_nxt;
  logic [2:0][BW-1:0]          b_r, b_nxt;
  logic [AW-1:0]               scan_idx_r, scan_idx_nxt;

  // Scan pipeline.
  logic                        v1_r, v2_r, v3_r;
  logic [AW-1:0]               idx1_r, idx2_r, idx3_r;
  logic [2:0][pbnc_pkg::PROD_W-1:0] prod_r, prod_nxt;
  logic [pbnc_pkg::SQ_W-1:0]   sq_r, sq_nxt;
  logic signed [pbnc_pkg::ERR_W-1:0] err_r, err_nxt;
  logic signed [pbnc_pkg::ERR_W-1:0] best_r;
  logic                        best_valid_r;
  logic [AW-1:0]               best_idx_r;
  logic                        take;
  logic                        drained;

  logic                        out_valid_r, out_valid_nxt;
  logic [7:0]                  out_index_r;
  logic                        out_load;

  pbnc_ram #(
    .WIDTH (pbnc_pkg::RGB_W),
    .DEPTH (PALETTE_ENTRIES)
  ) u_palette (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (q_item.rgb),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign ram_waddr = q_item.entry_index[AW-1:0];
  assign drained   = !v1_r && !v2_r && !v3_r;

  // Blend: B = 4096*c1 + w1*(c2 - c1), per component.
  always_comb begin
    logic [CW-1:0]     c1k, c2k;
    logic signed [8:0] d;
    logic signed [21:0] m, s;
    for (int k = 0; k < 3; k++) begin
      c1k = qry_r.first_ok  ? c1_r[k*CW +: CW]      : '0;
      c2k = qry_r.second_ok ? ram_rdata[k*CW +: CW] : '0;
      d   = $signed({1'b0, c2k}) - $signed({1'b0, c1k});
      m   = d * $signed({1'b0, w1});
      s   = $signed({2'b00, c1k, {pbnc_pkg::FRAC_BITS{1'b0}}}) + m;
      b_nxt[k] = s[BW-1:0];
    end
  end

  // Stage two: products against the blend and the squared norm.
  always_comb begin
    logic [CW-1:0] pk;
    sq_nxt = '0;
    for (int k = 0; k < 3; k++) begin
      pk          = ram_rdata[k*CW +: CW];
      prod_nxt[k] = pbnc_pkg::PROD_W'(pk * b_r[k]);
      sq_nxt      = sq_nxt + pbnc_pkg::SQ_W'(pk * pk);
    end
  end

  // Stage three: error of the entry.
  always_comb begin
    logic [pbnc_pkg::PSUM_W-1:0] psum;
    logic [pbnc_pkg::SQ_W+pbnc_pkg::SQ_SHIFT-1:0] sq_sh;
    psum    = pbnc_pkg::PSUM_W'(prod_r[0]) + pbnc_pkg::PSUM_W'(prod_r[1])
            + pbnc_pkg::PSUM_W'(prod_r[2]);
    sq_sh   = {sq_r, {pbnc_pkg::SQ_SHIFT{1'b0}}};
    err_nxt = $signed(pbnc_pkg::ERR_W'(sq_sh)) - $signed({1'b0, psum});
  end

  assign take = v3_r && (!best_valid_r || (err_r < best_r));

  always_comb begin
    state_nxt     = state_r;
    qry_nxt       = qry_r;
    c1_nxt        = c1_r;
    scan_idx_nxt  = scan_idx_r;
    q_pop         = 1'b0;
    ram_we        = 1'b0;
    ram_raddr     = scan_idx_r;
    out_load      = 1'b0;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (state_r)
      pbnc_pkg::S_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          if (q_item.op == pbnc_pkg::OP_LOAD) begin
            ram_we = q_item.load_ok;
          end else begin
            qry_nxt   = q_item;
            state_nxt = pbnc_pkg::S_RD1;
          end
        end
      end
      pbnc_pkg::S_RD1: begin
        ram_raddr = qry_r.first_color[AW-1:0];
        state_nxt = pbnc_pkg::S_RD2;
      end
      pbnc_pkg::S_RD2: begin
        ram_raddr = qry_r.second_color[AW-1:0];
        c1_nxt    = ram_rdata;
        state_nxt = pbnc_pkg::S_BLEND;
      end
      pbnc_pkg::S_BLEND: begin
        scan_idx_nxt = AW'(PALETTE_ENTRIES - 1);
        state_nxt    = pbnc_pkg::S_SCAN;
      end
      pbnc_pkg::S_SCAN: begin
        ram_raddr = scan_idx_r;
        if (scan_idx_r == '0) begin
          state_nxt = pbnc_pkg::S_DRAIN;
        end else begin
          scan_idx_nxt = scan_idx_r - 1'b1;
        end
      end
      pbnc_pkg::S_DRAIN: begin
        if (drained) begin
          state_nxt = pbnc_pkg::S_DONE;
        end
      end
      pbnc_pkg::S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = pbnc_pkg::S_IDLE;
        end
      end
      default: state_nxt = pbnc_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= pbnc_pkg::S_IDLE;
      v1_r         <= 1'b0;
      v2_r         <= 1'b0;
      v3_r         <= 1'b0;
      best_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      v1_r        <= (state_r == pbnc_pkg::S_SCAN);
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      out_valid_r <= out_valid_nxt;
      if (state_r == pbnc_pkg::S_BLEND) begin
        best_valid_r <= 1'b0;
      end else if (take) begin
        best_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    qry_r      <= qry_nxt;
    c1_r       <= c1_nxt;
    scan_idx_r <= scan_idx_nxt;
    idx1_r     <= scan_idx_r;
    idx2_r     <= idx1_r;
    idx3_r     <= idx2_r;
    prod_r     <= prod_nxt;
    sq_r       <= sq_nxt;
    err_r      <= err_nxt;
    if (state_r == pbnc_pkg::S_BLEND) begin
      b_r <= b_nxt;
    end
    if (take) begin
      best_r     <= err_r;
      best_idx_r <= idx3_r;
    end
    if (out_load) begin
      out_index_r <= 8'(best_idx_r);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_nearest_index = out_index_r;

endmodule

>>> hdl/palette_blend_nearest_color_unit.sv
// Top level of the palette blend unit: configuration register, front end and back end.
//
// Load beats write one palette entry; query beats name two palette colors and return the
// index of the palette entry nearest to their alpha-weighted blend, ties going to the higher
// index. A load is written to the palette RAM straight from the idle state. A query holds the
// back end in order: the idle state takes it from the queue, two reads fetch the query
// colors, the blend state forms the blend, the scan reads one palette entry per cycle
// through the single read port of the palette RAM, the three-stage error pipeline drains,
// and the done state registers the result, shown on out_valid the cycle after. The palette
// comes up undefined and must be loaded before it is queried; there is no clearing pass
// after reset. A two-deep queue sits between the front end and the back end, so beats are
// taken while a query is scanning or while a finished result still waits on out_stall. The
// alpha register may be written only while the unit is idle; cfg_ready is always high.
module palette_blend_nearest_color_unit #(
  parameter int PALETTE_ENTRIES = pbnc_pkg::PALETTE_ENTRIES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  // Input channel.
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_cmd,
  input  logic [7:0] in_entry_index,
  input  logic [7:0] in_red,
  input  logic [7:0] in_green,
  input  logic [7:0] in_blue,
  input  logic [7:0] in_first_color,
  input  logic [7:0] in_second_color,
  // Result channel.
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_nearest_index,
  // Configuration channel.
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [6:0] cfg_alpha_percent
);

  logic              q_valid;
  logic              q_pop;
  pbnc_pkg::item_t   q_item;

  // The register keeps the weight of the second color rather than the percentage itself,
  // looked up once per configuration beat from a constant table.
  pbnc_pkg::weight_t w1_r, w1_nxt;

  assign cfg_ready = 1'b1;

  always_comb begin
    w1_nxt = w1_r;
    if (cfg_valid && cfg_ready) begin
      w1_nxt = pbnc_pkg::W1_TABLE[cfg_alpha_percent];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w1_r <= pbnc_pkg::W1_TABLE[pbnc_pkg::ALPHA_RESET];
    end else begin
      w1_r <= w1_nxt;
    end
  end

  // The front end decodes each beat and buffers it.
  pbnc_front #(
    .PALETTE_ENTRIES (PALETTE_ENTRIES)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_cmd          (in_cmd),
    .in_entry_index  (in_entry_index),
    .in_red          (in_red),
    .in_green        (in_green),
    .in_blue         (in_blue),
    .in_first_color  (in_first_color),
    .in_second_color (in_second_color),
    .q_valid         (q_valid),
    .q_item          (q_item),
    .q_pop           (q_pop)
  );

  // The back end owns the palette RAM and the result register.
  pbnc_back #(
    .PALETTE_ENTRIES (PALETTE_ENTRIES)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_valid           (q_valid),
    .q_item            (q_item),
    .q_pop             (q_pop),
    .w1                (w1_r),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_nearest_index (out_nearest_index)
  );

endmodule

>>> hdl/pbnc_checker.sv
// Port-level checker for the palette blend unit, bound to the top level.
module pbnc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       in_cmd,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_nearest_index
);

  // Queries accepted whose result has not yet been taken.
  logic [3:0] pending_r, pending_nxt;
  logic       q_acc, o_acc;

  assign q_acc = in_valid && !in_stall && in_cmd;
  assign o_acc = out_valid && !out_stall;

  always_comb begin
    pending_nxt = pending_r;
    if (q_acc && !o_acc) begin
      pending_nxt = pending_r + 1'b1;
    end else if (!q_acc && o_acc) begin
      pending_nxt = pending_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
    end else begin
      pending_r <= pending_nxt;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_nearest_index))
    else $error("result changed while stalled");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pending_r != 4'd0)
    else $error("result shown without an outstanding query");

  a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    pending_r <= 4'd4)
    else $error("more queries in flight than the unit can hold");

  a_ready_after_reset: assert property (@(posedge clk)
    !rst_n |=> !in_stall)
    else $error("input stalled right after reset");

endmodule

bind palette_blend_nearest_color_unit pbnc_checker u_pbnc_checker (.*);
